// ===== sv/asd_pkg.sv =====
package asd_pkg;

  localparam int WINDOW_LEN_DEF = 100;

  localparam int BIAS_W    = 31;
  localparam int CHG_W     = 31;
  localparam int THR_W     = 20;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  // reciprocal width: 2^(THR_W+clog2(W))/W stays below 2^21 for any W
  localparam int RECIP_W   = 21;

  localparam logic [CNT_W-1:0] STOP_LIMIT_RST = 16'd150;
  localparam logic [THR_W-1:0] ROT_LIMIT_RST  = 20'd2500;
  localparam logic [THR_W-1:0] THR_FLOOR_RST  = 20'd200;
  localparam logic [THR_W-1:0] THR_CEIL_RST   = 20'd700;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_LIMIT = 2'd0,
    CFG_ROT_LIMIT  = 2'd1,
    CFG_THR_FLOOR  = 2'd2,
    CFG_THR_CEIL   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] stop_limit;
    logic [THR_W-1:0] rot_limit;
    logic [THR_W-1:0] thr_floor;
    logic [THR_W-1:0] thr_ceil;
  } cfg_t;

  typedef struct packed {
    logic [CHG_W-1:0] mag;
    logic             nz;
  } chg_t;

endpackage

// ===== sv/adaptive_stillness_detector.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_stall   in_bias_now, in_bias_before
// out      out_valid / out_stall out_vehicle_stopped, out_threshold_ready,
//                                out_stillness_threshold
// cfg      cfg_we                cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; a result passes the input,
// change, multiply, quotient fix and result registers after its request is taken.
// The running sum is held as quotient and remainder of 3*sum/WINDOW_LEN, so
// the update loop is one narrow add, compare and clamp.
// Synchronous active-low reset; no clearing pass, ready for requests at once.
// Each stage loads when empty or draining, so bubbles fill under out_stall.
module adaptive_stillness_detector #(
  parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [asd_pkg::BIAS_W-1:0] in_bias_now,
  input  logic signed [asd_pkg::BIAS_W-1:0] in_bias_before,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_vehicle_stopped,
  output logic                              out_threshold_ready,
  output logic [asd_pkg::THR_W-1:0]         out_stillness_threshold,
  input  logic                              cfg_we,
  input  logic [asd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asd_pkg::CFG_W-1:0]         cfg_data
);
  import asd_pkg::*;

  localparam int WW = $clog2(WINDOW_LEN);

  cfg_t             cfg_r;
  logic             chg_valid;
  chg_t             chg;
  logic             chg_rdy;
  logic             div_valid;
  chg_t             div_chg;
  logic [THR_W-1:0] div_quo;
  logic [WW-1:0]    div_rem;
  logic             div_big;
  logic             div_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_limit <= STOP_LIMIT_RST;
      cfg_r.rot_limit  <= ROT_LIMIT_RST;
      cfg_r.thr_floor  <= THR_FLOOR_RST;
      cfg_r.thr_ceil   <= THR_CEIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STOP_LIMIT: cfg_r.stop_limit <= cfg_data[CNT_W-1:0];
        CFG_ROT_LIMIT:  cfg_r.rot_limit  <= cfg_data[THR_W-1:0];
        CFG_THR_FLOOR:  cfg_r.thr_floor  <= cfg_data[THR_W-1:0];
        CFG_THR_CEIL:   cfg_r.thr_ceil   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  asd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .bias_now    (in_bias_now),
    .bias_before (in_bias_before),
    .chg_valid   (chg_valid),
    .chg         (chg),
    .chg_rdy     (chg_rdy)
  );

  asd_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .chg_valid (chg_valid),
    .chg       (chg),
    .chg_rdy   (chg_rdy),
    .div_valid (div_valid),
    .div_chg   (div_chg),
    .div_quo   (div_quo),
    .div_rem   (div_rem),
    .div_big   (div_big),
    .div_rdy   (div_rdy)
  );

  asd_core #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_core (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .div_valid               (div_valid),
    .div_chg                 (div_chg),
    .div_quo                 (div_quo),
    .div_rem                 (div_rem),
    .div_big                 (div_big),
    .div_rdy                 (div_rdy),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_vehicle_stopped     (out_vehicle_stopped),
    .out_threshold_ready     (out_threshold_ready),
    .out_stillness_threshold (out_stillness_threshold)
  );

endmodule

// ===== sv/asd_front.sv =====
module asd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [asd_pkg::BIAS_W-1:0]   bias_now,
  input  logic signed [asd_pkg::BIAS_W-1:0]   bias_before,
  output logic                                chg_valid,
  output asd_pkg::chg_t                       chg,
  input  logic                                chg_rdy
);
  import asd_pkg::*;

  logic                     v1_r;
  logic                     v2_r;
  logic signed [BIAS_W-1:0] now_r;
  logic signed [BIAS_W-1:0] bef_r;
  chg_t                     chg_r;
  chg_t                     chg_nxt;
  logic                     ld1;
  logic                     ld2;
  logic [BIAS_W:0]          diff;
  logic [BIAS_W:0]          mag_w;

  assign ld2      = !v2_r || chg_rdy;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;

  always_comb begin
    diff        = {now_r[BIAS_W-1], now_r} - {bef_r[BIAS_W-1], bef_r};
    mag_w       = diff[BIAS_W] ? (~diff + 1'b1) : diff;
    chg_nxt.mag = mag_w[CHG_W-1:0];
    chg_nxt.nz  = |mag_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      now_r <= bias_now;
      bef_r <= bias_before;
    end
    if (ld2 && v1_r) chg_r <= chg_nxt;
  end

  assign chg_valid = v2_r;
  assign chg       = chg_r;

endmodule

// ===== sv/asd_div.sv =====
module asd_div #(
  parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  chg_valid,
  input  asd_pkg::chg_t                         chg,
  output logic                                  chg_rdy,
  output logic                                  div_valid,
  output asd_pkg::chg_t                         div_chg,
  output logic [asd_pkg::THR_W-1:0]             div_quo,
  output logic [$clog2(WINDOW_LEN)-1:0]         div_rem,
  output logic                                  div_big,
  input  logic                                  div_rdy
);
  import asd_pkg::*;

  localparam int WW = $clog2(WINDOW_LEN);
  localparam int XW = THR_W + WW;
  localparam int PW = XW + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << XW) / WINDOW_LEN);
  localparam logic [CHG_W+1:0]   BIG_LIM = (CHG_W+2)'(64'(WINDOW_LEN) << THR_W);
  localparam logic [WW:0]        WIN_R   = (WW+1)'(WINDOW_LEN);

  logic              v3_r;
  logic              v4_r;
  logic              ld3;
  logic              ld4;
  logic [CHG_W+1:0]  x3;
  logic [PW-1:0]     prod_w;
  logic [PW-1:0]     prod_r;
  logic              big3_r;
  logic [WW:0]       xlo_r;
  chg_t              chg3_r;
  logic [THR_W-1:0]  q_est;
  logic [2*WW+1:0]   qw_full;
  logic [WW:0]       r_est;
  logic              fix;
  logic [THR_W-1:0]  quo_nxt;
  logic [WW:0]       rem_full;
  logic [THR_W-1:0]  quo_r;
  logic [WW-1:0]     rem_r;
  logic              big4_r;
  chg_t              chg4_r;

  assign ld4     = !v4_r || div_rdy;
  assign ld3     = !v3_r || ld4;
  assign chg_rdy = ld3;

  // 3 * change, then quotient estimate by reciprocal multiply
  always_comb begin
    x3     = {2'b00, chg.mag} + {1'b0, chg.mag, 1'b0};
    prod_w = PW'(x3[XW-1:0]) * PW'(RECIP);
  end

  // estimate is low by at most one: one compare and subtract fixes it
  always_comb begin
    q_est    = prod_r[XW +: THR_W];
    qw_full  = q_est[WW:0] * WIN_R;
    r_est    = xlo_r - qw_full[WW:0];
    fix      = (r_est >= WIN_R);
    quo_nxt  = fix ? (q_est + 1'b1) : q_est;
    rem_full = fix ? (r_est - WIN_R) : r_est;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld3) v3_r <= chg_valid;
      if (ld4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && chg_valid) begin
      prod_r <= prod_w;
      big3_r <= (x3 >= BIG_LIM);
      xlo_r  <= x3[WW:0];
      chg3_r <= chg;
    end
    if (ld4 && v3_r) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_full[WW-1:0];
      big4_r <= big3_r;
      chg4_r <= chg3_r;
    end
  end

  assign div_valid = v4_r;
  assign div_chg   = chg4_r;
  assign div_quo   = quo_r;
  assign div_rem   = rem_r;
  assign div_big   = big4_r;

endmodule

// ===== sv/asd_core.sv =====
module asd_core #(
  parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  asd_pkg::cfg_t                   cfg,
  input  logic                            div_valid,
  input  asd_pkg::chg_t                   div_chg,
  input  logic [asd_pkg::THR_W-1:0]       div_quo,
  input  logic [$clog2(WINDOW_LEN)-1:0]   div_rem,
  input  logic                            div_big,
  output logic                            div_rdy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_vehicle_stopped,
  output logic                            out_threshold_ready,
  output logic [asd_pkg::THR_W-1:0]       out_stillness_threshold
);
  import asd_pkg::*;

  localparam int WW = $clog2(WINDOW_LEN);
  localparam int LW = WINDOW_LEN - 1;
  localparam logic [WW:0] WIN_R = (WW+1)'(WINDOW_LEN);

  logic             commit;
  logic             cal_r,   cal_nxt;
  logic [LW-1:0]    line_r,  line_nxt;
  logic [THR_W-1:0] qs_r,    qs_nxt;
  logic [WW-1:0]    rs_r,    rs_nxt;
  logic             big_r,   big_nxt;
  logic [THR_W-1:0] thr_r,   thr_nxt;
  logic [CNT_W-1:0] quiet_r, quiet_nxt;
  logic             stop_r,  stop_nxt;
  logic             out_valid_r;
  logic             out_stop_r;
  logic             out_ready_r;
  logic [THR_W-1:0] out_thr_r;

  logic [WW:0]      r_sum;
  logic [WW:0]      r_wrap;
  logic             carry;
  logic [THR_W+1:0] q_sum;
  logic             big_sum;
  logic             cal_hit;
  logic [THR_W-1:0] t_cal;
  logic [THR_W-1:0] thr_use;
  logic             quiet;

  assign div_rdy = !out_valid_r || !out_stall;
  assign commit  = div_valid && div_rdy;

  always_comb begin
    // running 3*sum/W kept as quotient and remainder
    r_sum   = {1'b0, rs_r} + {1'b0, div_rem};
    carry   = (r_sum >= WIN_R);
    r_wrap  = carry ? (r_sum - WIN_R) : r_sum;
    q_sum   = {2'b00, qs_r} + {2'b00, div_quo} + (THR_W+2)'(carry);
    big_sum = big_r || div_big || (|q_sum[THR_W+1:THR_W]);
    cal_hit = !cal_r && line_r[0];

    if (big_sum) begin
      t_cal = cfg.thr_ceil;
    end else if (q_sum[THR_W-1:0] < cfg.thr_floor) begin
      t_cal = cfg.thr_floor;
    end else if (q_sum[THR_W-1:0] > cfg.thr_ceil) begin
      t_cal = cfg.thr_ceil;
    end else begin
      t_cal = q_sum[THR_W-1:0];
    end

    if (cal_r) begin
      thr_use = thr_r;
    end else if (cal_hit) begin
      thr_use = t_cal;
    end else begin
      thr_use = cfg.thr_ceil;
    end

    quiet = (div_chg.mag < {{(CHG_W-THR_W){1'b0}}, thr_use});

    cal_nxt   = cal_r;
    line_nxt  = line_r;
    qs_nxt    = qs_r;
    rs_nxt    = rs_r;
    big_nxt   = big_r;
    thr_nxt   = thr_r;
    quiet_nxt = quiet_r;
    stop_nxt  = stop_r;

    if (commit) begin
      if (cal_hit) begin
        cal_nxt  = 1'b1;
        thr_nxt  = t_cal;
        line_nxt = '0;
        qs_nxt   = '0;
        rs_nxt   = '0;
        big_nxt  = 1'b0;
      end else if (!cal_r) begin
        line_nxt = (line_r >> 1) | (LW'(div_chg.nz) << (LW - 1));
        qs_nxt   = q_sum[THR_W-1:0];
        rs_nxt   = r_wrap[WW-1:0];
        big_nxt  = big_sum;
      end

      if (quiet) begin
        if (quiet_r >= cfg.stop_limit) begin
          stop_nxt  = 1'b1;
          quiet_nxt = '0;
        end else begin
          quiet_nxt = quiet_r + 1'b1;
        end
      end else begin
        quiet_nxt = '0;
        stop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r       <= 1'b0;
      line_r      <= '0;
      qs_r        <= '0;
      rs_r        <= '0;
      big_r       <= 1'b0;
      thr_r       <= THR_CEIL_RST;
      quiet_r     <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cal_r   <= cal_nxt;
      line_r  <= line_nxt;
      qs_r    <= qs_nxt;
      rs_r    <= rs_nxt;
      big_r   <= big_nxt;
      thr_r   <= thr_nxt;
      quiet_r <= quiet_nxt;
      stop_r  <= stop_nxt;
      if (div_rdy) out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_stop_r  <= stop_nxt;
      out_ready_r <= cal_nxt;
      out_thr_r   <= thr_use;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_vehicle_stopped     = out_stop_r;
  assign out_threshold_ready     = out_ready_r;
  assign out_stillness_threshold = out_thr_r;

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |=> cal_r)
    else $error("calibration dropped");

  a_cal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |-> (line_r == '0 && !big_r && qs_r == '0))
    else $error("window state left after calibration");

  a_stop_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stop_r) |-> quiet_r == '0)
    else $error("stop flag raised without clearing count");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !cal_r) |-> !out_ready_r)
    else $error("result shows calibrated before calibration");

endmodule
